// ===== hdl/plb_pkg.sv =====
// plb_pkg: command codes and field widths of the positional list buffer
// no dependencies; used by the interfaces, plb_store, plb_ctrl and positional_list_buffer

package plb_pkg;

    // widths of the item fields
    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int LEN_W = 5;

    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [LEN_W-1:0] len_t;

    // command codes
    localparam cmd_t CMD_INSERT   = 2'd0;
    localparam cmd_t CMD_REMOVE   = 2'd1;
    localparam cmd_t CMD_RETRIEVE = 2'd2;

endpackage

// ===== hdl/plb_in_if.sv =====
// plb_in_if: request channel (valid, ready, cmd, position, value)
// depends on plb_pkg

interface plb_in_if;
    logic           valid;
    logic           ready;
    plb_pkg::cmd_t  cmd;
    plb_pkg::pos_t  position;
    plb_pkg::val_t  value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== hdl/plb_out_if.sv =====
// plb_out_if: result channel (valid, ready, ok, read_value, length)
// depends on plb_pkg

interface plb_out_if;
    logic           valid;
    logic           ready;
    logic           ok;
    plb_pkg::val_t  read_value;
    plb_pkg::len_t  length;

    modport source (output valid, output ok, output read_value, output length, input ready);
    modport sink   (input valid, input ok, input read_value, input length, output ready);
endinterface

// ===== hdl/plb_store.sv =====
// plb_store: list storage, one write port and one read port with registered read data
// depends on plb_pkg

module plb_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  plb_pkg::val_t wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output plb_pkg::val_t rdata
);

    plb_pkg::val_t mem [DEPTH];
    plb_pkg::val_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered data valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/plb_ctrl.sv =====
// plb_ctrl: request decode, entry-move sequencer with one shared step unit, result register
// depends on plb_pkg, plb_in_if, plb_out_if

module plb_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    plb_in_if.sink            req,
    plb_out_if.source         rsp,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output plb_pkg::val_t     mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  plb_pkg::val_t     mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > plb_pkg::POS_W) ? CW : plb_pkg::POS_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_WRITE = 6'b000100,
        S_PUT   = 6'b001000,
        S_GRAB  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    plb_pkg::cmd_t   cmd_reg, cmd_next;
    plb_pkg::val_t   value_reg, value_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   limit_reg, limit_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            res_ok_reg, res_ok_next;
    plb_pkg::val_t   res_rd_reg, res_rd_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_ok_reg, out_ok_next;
    plb_pkg::val_t   out_rd_reg, out_rd_next;
    plb_pkg::len_t   out_len_reg, out_len_next;

    logic [PW-1:0]   pos_w, cnt_w, pos_m1_w;
    logic [CW-1:0]   pos_m1;
    logic [CW-1:0]   cnt_m1;
    logic            pos_nz, ins_ok, rem_ok;
    logic [CW-1:0]   step;
    logic            step_hit;

    // range checks on the incoming item
    always_comb
    begin
        pos_w    = PW'(req.position);
        cnt_w    = PW'(count_reg);
        pos_m1_w = pos_w - PW'(1);
        pos_m1   = pos_m1_w[CW-1:0];
        cnt_m1   = count_reg - CW'(1);
        pos_nz   = (req.position != '0);
        ins_ok   = pos_nz && (pos_w <= cnt_w + PW'(1)) && (cnt_w < PW'(DEPTH));
        rem_ok   = pos_nz && (pos_w <= cnt_w);
    end

    // shared step unit: next pointer and end-of-move compare
    assign step     = (cmd_reg == plb_pkg::CMD_INSERT) ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
    assign step_hit = (step == limit_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        value_next  = value_reg;
        ptr_next    = ptr_reg;
        limit_next  = limit_reg;
        count_next  = count_reg;
        res_ok_next = res_ok_reg;
        res_rd_next = res_rd_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = step[AW-1:0];
        req.ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    value_next  = req.value;
                    res_ok_next = 1'b0;
                    res_rd_next = '0;
                    state_next  = S_DONE;
                    case (req.cmd)
                        plb_pkg::CMD_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                ptr_next   = count_reg;
                                limit_next = pos_m1;
                                state_next = (count_reg == pos_m1) ? S_PUT : S_READ;
                            end
                        end
                        plb_pkg::CMD_REMOVE:
                        begin
                            if (rem_ok)
                            begin
                                ptr_next   = pos_m1;
                                limit_next = cnt_m1;
                                if (pos_m1 == cnt_m1)
                                begin
                                    count_next  = cnt_m1;
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        plb_pkg::CMD_RETRIEVE:
                        begin
                            if (rem_ok)
                            begin
                                ptr_next   = pos_m1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;
                if (cmd_reg == plb_pkg::CMD_RETRIEVE)
                begin
                    mem_raddr  = ptr_reg[AW-1:0];
                    state_next = S_GRAB;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                mem_we   = 1'b1;
                ptr_next = step;
                if (!step_hit)
                begin
                    state_next = S_READ;
                end
                else if (cmd_reg == plb_pkg::CMD_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    count_next  = cnt_m1;
                    res_ok_next = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_PUT:
            begin
                mem_we      = 1'b1;
                mem_wdata   = value_reg;
                count_next  = count_reg + CW'(1);
                res_ok_next = 1'b1;
                state_next  = S_DONE;
            end
            S_GRAB:
            begin
                res_ok_next = 1'b1;
                res_rd_next = mem_rdata;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register, loaded when the finished item can leave
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_rd_next    = out_rd_reg;
        out_len_next   = out_len_reg;
        if ((state_reg == S_DONE) && (!out_valid_reg || rsp.ready))
        begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok_reg;
            out_rd_next    = res_rd_reg;
            out_len_next   = plb_pkg::LEN_W'(count_reg);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.read_value = out_rd_reg;
    assign rsp.length     = out_len_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        ptr_reg     <= ptr_next;
        limit_reg   <= limit_next;
        res_ok_reg  <= res_ok_next;
        res_rd_reg  <= res_rd_next;
        out_ok_reg  <= out_ok_next;
        out_rd_reg  <= out_rd_next;
        out_len_reg <= out_len_next;
    end

`ifndef ASSERT_OFF
    // the list never holds more than its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length above capacity");

    // placing the new word grows the list by exactly one
    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list by one");

    // the move pointer stays inside the storage
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_WRITE || state_reg == S_PUT)
        |-> (ptr_reg < CW'(DEPTH)))
        else $error("move pointer outside storage");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_len_reg)
        && $stable(out_ok_reg)))
        else $error("pending result overwritten");
`endif

endmodule

// ===== hdl/positional_list_buffer.sv =====
// positional_list_buffer: ordered list of signed 32-bit words addressed by 1-based position
// depends on plb_pkg, plb_in_if, plb_out_if, plb_store, plb_ctrl
//
// usage: requests arrive on req (cmd, position, value) and each gives exactly one item
// on rsp (ok, read_value, length). cmd insert puts value at position and moves later
// entries up, remove drops the entry at position and moves later entries down, retrieve
// reads the entry at position. a position out of range, an insert into a full list or an
// unused command returns ok low, read_value zero and the list unchanged.
// timing: one item at a time; req.ready is high only while the sequencer is idle. entries
// are moved one at a time through the single storage port pair, each with a read and then
// a write. insert moves the entries from p to the end up one place, last first, and then
// writes the new value; remove moves the entries after p down; retrieve reads the entry at
// p and then takes its data; a refused request goes straight to the result. the sequencer
// is idle again from the edge that loads the result register, and the next request can follow.
// reset: asynchronous, clears the length and the result valid; storage is not cleared,
// an entry is only ever read after it was written.
// stall: the result waits in the output register while rsp.ready is low; a further request
// is accepted meanwhile and its result waits inside until the register is free.

module positional_list_buffer #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    plb_in_if.sink    req,
    plb_out_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    plb_pkg::val_t mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    plb_pkg::val_t mem_rdata;

    // sequencer and result register
    plb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // list storage
    plb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
